### rtl/core/sntc_pkg.sv
package sntc_pkg;

  // cell type codes
  localparam logic [3:0] TYPE_U8     = 4'd0;
  localparam logic [3:0] TYPE_I8     = 4'd1;
  localparam logic [3:0] TYPE_U16    = 4'd2;
  localparam logic [3:0] TYPE_I16    = 4'd3;
  localparam logic [3:0] TYPE_U32    = 4'd4;
  localparam logic [3:0] TYPE_I32    = 4'd5;
  localparam logic [3:0] TYPE_U64    = 4'd6;
  localparam logic [3:0] TYPE_I64    = 4'd7;
  localparam logic [3:0] TYPE_FLOAT  = 4'd8;
  localparam logic [3:0] TYPE_DOUBLE = 4'd9;

  // configuration register indexes
  localparam logic CFG_SOURCE_TYPE = 1'b0;
  localparam logic CFG_TARGET_TYPE = 1'b1;

  // value in double range: man * 2^(exp-52), man normalized unless zero
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sign;
    logic signed [12:0] exp;
    logic [52:0]        man;
  } num_t;

  typedef struct packed {
    logic [5:0]  lzc;
    logic [63:0] norm;
  } norm_t;

  // bits of a cell of the given type
  function automatic logic [6:0] type_width(input logic [3:0] code);
    logic [6:0] w;
    case (code) inside
      TYPE_U8, TYPE_I8:                   w = 7'd8;
      TYPE_U16, TYPE_I16:                 w = 7'd16;
      TYPE_U32, TYPE_I32, TYPE_FLOAT:     w = 7'd32;
      default:                            w = 7'd64;
    endcase
    return w;
  endfunction

  function automatic logic [63:0] width_mask(input logic [3:0] code);
    logic [63:0] m;
    case (code) inside
      TYPE_U8, TYPE_I8:                   m = 64'h0000_0000_0000_00FF;
      TYPE_U16, TYPE_I16:                 m = 64'h0000_0000_0000_FFFF;
      TYPE_U32, TYPE_I32, TYPE_FLOAT:     m = 64'h0000_0000_FFFF_FFFF;
      default:                            m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // leading zero count and left normalize in six halving steps
  function automatic norm_t normalize(input logic [63:0] mag);
    norm_t r;
    r.norm = mag;
    r.lzc  = 6'd0;
    if (r.norm[63:32] == 32'd0) begin r.norm = r.norm << 32; r.lzc[5] = 1'b1; end
    if (r.norm[63:48] == 16'd0) begin r.norm = r.norm << 16; r.lzc[4] = 1'b1; end
    if (r.norm[63:56] == 8'd0)  begin r.norm = r.norm << 8;  r.lzc[3] = 1'b1; end
    if (r.norm[63:60] == 4'd0)  begin r.norm = r.norm << 4;  r.lzc[2] = 1'b1; end
    if (r.norm[63:62] == 2'd0)  begin r.norm = r.norm << 2;  r.lzc[1] = 1'b1; end
    if (r.norm[63] == 1'b0)     begin r.norm = r.norm << 1;  r.lzc[0] = 1'b1; end
    return r;
  endfunction

endpackage

### rtl/core/sntc_unpack.sv
module sntc_unpack (
  input  logic                clk,
  input  logic                en,
  input  logic [3:0]          source_type,
  input  logic [63:0]         raw_in,
  output sntc_pkg::num_t      num,
  output logic [63:0]         nan_bits,
  output logic [63:0]         raw_out
);

  logic [63:0]        mag;
  logic signed [12:0] adj;
  logic               sgn;
  logic               is_nan;
  logic               is_inf;
  logic [63:0]        nb;
  logic [63:0]        sx;
  logic [7:0]         fexp;
  logic [10:0]        dexp;
  sntc_pkg::norm_t    nr;

  // stage two registers: normalized magnitude
  logic               s2_nan;
  logic               s2_inf;
  logic               s2_zero;
  logic               s2_sign;
  logic signed [12:0] s2_exp;
  logic [63:0]        s2_norm;
  logic [63:0]        s2_nb;
  logic [63:0]        s2_raw;

  // round stage
  logic [52:0]        keep;
  logic               rup;
  logic [53:0]        rsum;
  sntc_pkg::num_t     num_next;

  // source cell to sign, magnitude and exponent offset
  always_comb begin
    mag    = 64'd0;
    adj    = 13'sd0;
    sgn    = 1'b0;
    is_nan = 1'b0;
    is_inf = 1'b0;
    nb     = raw_in;
    sx     = 64'd0;
    fexp   = raw_in[30:23];
    dexp   = raw_in[62:52];
    case (source_type)
      sntc_pkg::TYPE_U8:  mag = {56'd0, raw_in[7:0]};
      sntc_pkg::TYPE_I8: begin
        sx  = 64'($signed(raw_in[7:0]));
        sgn = raw_in[7];
        mag = sgn ? -sx : sx;
      end
      sntc_pkg::TYPE_U16: mag = {48'd0, raw_in[15:0]};
      sntc_pkg::TYPE_I16: begin
        sx  = 64'($signed(raw_in[15:0]));
        sgn = raw_in[15];
        mag = sgn ? -sx : sx;
      end
      sntc_pkg::TYPE_U32: mag = {32'd0, raw_in[31:0]};
      sntc_pkg::TYPE_I32: begin
        sx  = 64'($signed(raw_in[31:0]));
        sgn = raw_in[31];
        mag = sgn ? -sx : sx;
      end
      sntc_pkg::TYPE_U64: mag = raw_in;
      sntc_pkg::TYPE_I64: begin
        sgn = raw_in[63];
        mag = sgn ? -raw_in : raw_in;
      end
      sntc_pkg::TYPE_FLOAT: begin
        sgn    = raw_in[31];
        is_nan = (fexp == 8'hFF) && (raw_in[22:0] != 23'd0);
        is_inf = (fexp == 8'hFF) && (raw_in[22:0] == 23'd0);
        mag    = {40'd0, fexp != 8'd0, raw_in[22:0]};
        adj    = $signed(13'((fexp == 8'd0) ? 8'd1 : fexp)) - 13'sd150;
        nb     = {raw_in[31], 12'hFFF, raw_in[21:0], 29'd0};
      end
      sntc_pkg::TYPE_DOUBLE: begin
        sgn    = raw_in[63];
        is_nan = (dexp == 11'h7FF) && (raw_in[51:0] != 52'd0);
        is_inf = (dexp == 11'h7FF) && (raw_in[51:0] == 52'd0);
        mag    = {11'd0, dexp != 11'd0, raw_in[51:0]};
        adj    = $signed(13'((dexp == 11'd0) ? 11'd1 : dexp)) - 13'sd1075;
      end
      default: mag = 64'd0;
    endcase
    nr = sntc_pkg::normalize(mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_nan  <= is_nan;
      s2_inf  <= is_inf;
      s2_zero <= (mag == 64'd0) && !is_nan && !is_inf;
      s2_sign <= sgn;
      s2_exp  <= adj + 13'sd63 - $signed(13'(nr.lzc));
      s2_norm <= nr.norm;
      s2_nb   <= nb;
      s2_raw  <= raw_in;
    end
  end

  // round to 53 bits, nearest even
  always_comb begin
    keep          = s2_norm[63:11];
    rup           = s2_norm[10] && ((|s2_norm[9:0]) || keep[0]);
    rsum          = {1'b0, keep} + 54'(rup);
    num_next.nan  = s2_nan;
    num_next.inf  = s2_inf;
    num_next.zero = s2_zero;
    num_next.sign = s2_sign;
    if (rsum[53]) begin
      num_next.man = rsum[53:1];
      num_next.exp = s2_exp + 13'sd1;
    end else begin
      num_next.man = rsum[52:0];
      num_next.exp = s2_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num      <= num_next;
      nan_bits <= s2_nb;
      raw_out  <= s2_raw;
    end
  end

endmodule

### rtl/core/sntc_pack.sv
module sntc_pack (
  input  logic [3:0]      source_type,
  input  logic [3:0]      target_type,
  input  sntc_pkg::num_t  num,
  input  logic [63:0]     nan_bits,
  input  logic [63:0]     raw,
  output logic [63:0]     result
);

  logic [63:0]  mask;
  logic         sgnd;
  logic [6:0]   k;
  logic         ovf;
  logic [116:0] iwide;
  logic [63:0]  ip;
  logic [63:0]  int_res;

  logic [12:0]  tshift;
  logic [6:0]   r;
  logic         fnorm;
  logic [116:0] fwide;
  logic         frup;
  logic [7:0]   bef;
  logic [31:0]  fp;
  logic         fbig;
  logic [31:0]  flt_res;
  logic [63:0]  dbl_res;
  logic [12:0]  dexp;

  // integer target: clamp then truncate toward zero
  always_comb begin
    mask  = sntc_pkg::width_mask(target_type);
    sgnd  = target_type[0];
    k     = sntc_pkg::type_width(target_type) - 7'(sgnd);
    ovf   = num.inf || (num.exp >= $signed(13'(k)));
    iwide = 117'(num.man) << num.exp[5:0];
    ip    = (num.exp < 13'sd0) ? 64'd0 : iwide[115:52];
    if (num.nan || num.zero) begin
      int_res = 64'd0;
    end else if (num.sign) begin
      if (!sgnd)    int_res = 64'd0;
      else if (ovf) int_res = mask ^ (mask >> 1);
      else          int_res = (-ip) & mask;
    end else begin
      if (ovf) int_res = sgnd ? (mask >> 1) : mask;
      else     int_res = ip;
    end
  end

  // float target: round to nearest even, saturate to largest finite
  always_comb begin
    fnorm  = num.exp >= -13'sd126;
    tshift = -num.exp - 13'sd97;
    if (fnorm)                          r = 7'd29;
    else if ($signed(tshift) > 13'sd64) r = 7'd64;
    else                                r = tshift[6:0];
    fwide   = {num.man, 64'd0} >> r;
    frup    = fwide[63] && ((|fwide[62:0]) || fwide[64]);
    bef     = fnorm ? 8'(num.exp + 13'sd127) : 8'd0;
    fp      = {1'b0, bef, fwide[86:64]} + 32'(frup);
    fbig    = num.inf || (num.exp > 13'sd127) || (fp[30:23] == 8'hFF);
    if (num.nan)       flt_res = {nan_bits[63], 9'h1FF, nan_bits[50:29]};
    else if (num.zero) flt_res = {num.sign, 31'd0};
    else if (fbig)     flt_res = {num.sign, 31'h7F7F_FFFF};
    else               flt_res = {num.sign, fp[30:0]};
  end

  // double target: exact repack, infinity saturates to largest finite
  always_comb begin
    dexp = num.exp + 13'sd1023;
    if (num.nan)       dbl_res = nan_bits;
    else if (num.inf)  dbl_res = {num.sign, 63'h7FEF_FFFF_FFFF_FFFF};
    else if (num.zero) dbl_res = {num.sign, 63'd0};
    else               dbl_res = {num.sign, dexp[10:0], num.man[51:0]};
  end

  // select by type pair
  always_comb begin
    if (source_type > sntc_pkg::TYPE_DOUBLE || target_type > sntc_pkg::TYPE_DOUBLE) begin
      result = 64'd0;
    end else if (source_type == target_type) begin
      result = raw & sntc_pkg::width_mask(source_type);
    end else if (target_type == sntc_pkg::TYPE_FLOAT) begin
      result = {32'd0, flt_res};
    end else if (target_type == sntc_pkg::TYPE_DOUBLE) begin
      result = dbl_res;
    end else begin
      result = int_res;
    end
  end

endmodule

### rtl/core/saturating_numeric_type_convert.sv
// throughput: one transaction per cycle, four register stages in a line
// (input, normalize, round, pack) that all move together when the output is free
// reset (synchronous, active high) empties the pipeline and sets both type
// registers to u8
module saturating_numeric_type_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] cell_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] converted_value
);

  logic [3:0]     source_type;
  logic [3:0]     target_type;
  logic           advance;
  logic           v1;
  logic           v2;
  logic           v3;
  logic [63:0]    raw1;
  sntc_pkg::num_t num3;
  logic [63:0]    nan_bits3;
  logic [63:0]    raw3;
  logic [63:0]    converted_value_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_type <= sntc_pkg::TYPE_U8;
      target_type <= sntc_pkg::TYPE_U8;
    end else if (cfg_we) begin
      if (cfg_index == sntc_pkg::CFG_SOURCE_TYPE) source_type <= cfg_data;
      if (cfg_index == sntc_pkg::CFG_TARGET_TYPE) target_type <= cfg_data;
    end
  end

  // whole pipeline moves unless the result is held
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (advance) raw1 <= cell_bits;
  end

  sntc_unpack u_unpack (
    .clk         (clk),
    .en          (advance),
    .source_type (source_type),
    .raw_in      (raw1),
    .num         (num3),
    .nan_bits    (nan_bits3),
    .raw_out     (raw3)
  );

  sntc_pack u_pack (
    .source_type (source_type),
    .target_type (target_type),
    .num         (num3),
    .nan_bits    (nan_bits3),
    .raw         (raw3),
    .result      (converted_value_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (advance) converted_value <= converted_value_next;
  end

  // an accepted transaction enters the first stage
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted transaction lost at input stage");

  // last stage reaches the output when free
  a_last_to_out : assert property (@(posedge clk) disable iff (rst)
    v3 && !in_stall |=> out_valid)
    else $error("transaction lost before output");

  // an empty output never stalls the input
  a_empty_no_stall : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule
